// ===== sv/btpc_pkg.sv =====
// Shared types, constants and the compensation microprogram for the barometer block.
package btpc_pkg;

    // Field and register widths.
    localparam int RAW_W      = 24;
    localparam int DATA_W     = 64;
    localparam int TEMP_W     = 40;
    localparam int PRESS_AB_W = 48;
    localparam int PRESS_C_W  = 32;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 2'd3;

    // Scratch register file and program sequencing.
    localparam int SCR_DEPTH = 8;
    localparam int SCR_AW    = 3;
    localparam int PC_W      = 6;
    localparam int SH_W      = 6;
    localparam logic [PC_W-1:0] PC_TEMP  = 6'd0;
    localparam logic [PC_W-1:0] PC_PRESS = 6'd10;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SHL,
        OP_SHR,
        OP_SDIV
    } t_op;

    // Operand sources; codes below SCR_DEPTH address the scratch registers.
    typedef enum logic [4:0] {
        SRC_R0     = 5'd0,
        SRC_R1     = 5'd1,
        SRC_R2     = 5'd2,
        SRC_R3     = 5'd3,
        SRC_R4     = 5'd4,
        SRC_R5     = 5'd5,
        SRC_R6     = 5'd6,
        SRC_R7     = 5'd7,
        SRC_RAW    = 5'd8,
        SRC_LT     = 5'd9,
        SRC_T1     = 5'd10,
        SRC_T2     = 5'd11,
        SRC_T3     = 5'd12,
        SRC_P1     = 5'd13,
        SRC_P2     = 5'd14,
        SRC_P3     = 5'd15,
        SRC_P4     = 5'd16,
        SRC_P5     = 5'd17,
        SRC_P6     = 5'd18,
        SRC_P7     = 5'd19,
        SRC_P8     = 5'd20,
        SRC_P9     = 5'd21,
        SRC_P10    = 5'd22,
        SRC_P11    = 5'd23,
        SRC_K16384 = 5'd24,
        SRC_K25    = 5'd25,
        SRC_ZERO   = 5'd26
    } t_src;

    // One microinstruction: dst = op(src_a, src_b), shift amount in sh.
    typedef struct packed {
        t_op             op;
        t_src            src_a;
        t_src            src_b;
        t_src            dst;
        logic [SH_W-1:0] sh;
        logic            wr_lt;
        logic            last;
    } t_instr;

    function automatic t_instr mk(input t_op op, input t_src a, input t_src b,
                                  input t_src d, input logic [SH_W-1:0] sh,
                                  input logic wr_lt, input logic last);
        t_instr ins;
        ins.op    = op;
        ins.src_a = a;
        ins.src_b = b;
        ins.dst   = d;
        ins.sh    = sh;
        ins.wr_lt = wr_lt;
        ins.last  = last;
        return ins;
    endfunction

    // Microprogram. Temperature runs from PC_TEMP, pressure from PC_PRESS.
    function automatic t_instr prog_rom(input logic [PC_W-1:0] pc);
        t_instr ins;
        ins = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_R7, 6'd0, 1'b0, 1'b1);
        case (pc)
            // Temperature: a = raw - 256*t1, e = t2*a*2^18 + a*a*t3.
            6'd0:  ins = mk(OP_SHL,  SRC_T1,  SRC_ZERO,   SRC_R0, 6'd8,  1'b0, 1'b0);
            6'd1:  ins = mk(OP_SUB,  SRC_RAW, SRC_R0,     SRC_R0, 6'd0,  1'b0, 1'b0);
            6'd2:  ins = mk(OP_MUL,  SRC_T2,  SRC_R0,     SRC_R1, 6'd0,  1'b0, 1'b0);
            6'd3:  ins = mk(OP_MUL,  SRC_R0,  SRC_R0,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd4:  ins = mk(OP_MUL,  SRC_R2,  SRC_T3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd5:  ins = mk(OP_SHL,  SRC_R1,  SRC_ZERO,   SRC_R1, 6'd18, 1'b0, 1'b0);
            6'd6:  ins = mk(OP_ADD,  SRC_R1,  SRC_R2,     SRC_R1, 6'd0,  1'b0, 1'b0);
            6'd7:  ins = mk(OP_SDIV, SRC_R1,  SRC_ZERO,   SRC_R1, 6'd32, 1'b1, 1'b0);
            6'd8:  ins = mk(OP_MUL,  SRC_R1,  SRC_K25,    SRC_R1, 6'd0,  1'b0, 1'b0);
            6'd9:  ins = mk(OP_SDIV, SRC_R1,  SRC_ZERO,   SRC_R1, 6'd14, 1'b0, 1'b1);
            // Pressure: square and cube of the linearized temperature.
            6'd10: ins = mk(OP_MUL,  SRC_LT,  SRC_LT,     SRC_R0, 6'd0,  1'b0, 1'b0);
            6'd11: ins = mk(OP_SDIV, SRC_R0,  SRC_ZERO,   SRC_R1, 6'd6,  1'b0, 1'b0);
            6'd12: ins = mk(OP_MUL,  SRC_R1,  SRC_LT,     SRC_R1, 6'd0,  1'b0, 1'b0);
            6'd13: ins = mk(OP_SDIV, SRC_R1,  SRC_ZERO,   SRC_R1, 6'd8,  1'b0, 1'b0);
            // Offset term, divided by four at the end.
            6'd14: ins = mk(OP_SHL,  SRC_P5,  SRC_ZERO,   SRC_R2, 6'd47, 1'b0, 1'b0);
            6'd15: ins = mk(OP_MUL,  SRC_P8,  SRC_R1,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd16: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd5,  1'b0, 1'b0);
            6'd17: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd18: ins = mk(OP_MUL,  SRC_P7,  SRC_R0,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd19: ins = mk(OP_SHL,  SRC_R3,  SRC_ZERO,   SRC_R3, 6'd4,  1'b0, 1'b0);
            6'd20: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd21: ins = mk(OP_MUL,  SRC_P6,  SRC_LT,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd22: ins = mk(OP_SHL,  SRC_R3,  SRC_ZERO,   SRC_R3, 6'd22, 1'b0, 1'b0);
            6'd23: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd24: ins = mk(OP_SDIV, SRC_R2,  SRC_ZERO,   SRC_R2, 6'd2,  1'b0, 1'b0);
            // Sensitivity term, scaled and multiplied by the raw sample.
            6'd25: ins = mk(OP_SUB,  SRC_P1,  SRC_K16384, SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd26: ins = mk(OP_SHL,  SRC_R3,  SRC_ZERO,   SRC_R3, 6'd46, 1'b0, 1'b0);
            6'd27: ins = mk(OP_MUL,  SRC_P4,  SRC_R1,     SRC_R4, 6'd0,  1'b0, 1'b0);
            6'd28: ins = mk(OP_SDIV, SRC_R4,  SRC_ZERO,   SRC_R4, 6'd5,  1'b0, 1'b0);
            6'd29: ins = mk(OP_ADD,  SRC_R3,  SRC_R4,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd30: ins = mk(OP_MUL,  SRC_P3,  SRC_R0,     SRC_R4, 6'd0,  1'b0, 1'b0);
            6'd31: ins = mk(OP_SHL,  SRC_R4,  SRC_ZERO,   SRC_R4, 6'd2,  1'b0, 1'b0);
            6'd32: ins = mk(OP_ADD,  SRC_R3,  SRC_R4,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd33: ins = mk(OP_SUB,  SRC_P2,  SRC_K16384, SRC_R4, 6'd0,  1'b0, 1'b0);
            6'd34: ins = mk(OP_MUL,  SRC_R4,  SRC_LT,     SRC_R4, 6'd0,  1'b0, 1'b0);
            6'd35: ins = mk(OP_SHL,  SRC_R4,  SRC_ZERO,   SRC_R4, 6'd21, 1'b0, 1'b0);
            6'd36: ins = mk(OP_ADD,  SRC_R3,  SRC_R4,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd37: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd24, 1'b0, 1'b0);
            6'd38: ins = mk(OP_MUL,  SRC_R3,  SRC_RAW,    SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd39: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            // Quadratic term.
            6'd40: ins = mk(OP_MUL,  SRC_P10, SRC_LT,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd41: ins = mk(OP_SHL,  SRC_P9,  SRC_ZERO,   SRC_R4, 6'd16, 1'b0, 1'b0);
            6'd42: ins = mk(OP_ADD,  SRC_R3,  SRC_R4,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd43: ins = mk(OP_MUL,  SRC_R3,  SRC_RAW,    SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd44: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd13, 1'b0, 1'b0);
            6'd45: ins = mk(OP_MUL,  SRC_R3,  SRC_RAW,    SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd46: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd9,  1'b0, 1'b0);
            6'd47: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            // Cubic term, then the final scaling.
            6'd48: ins = mk(OP_MUL,  SRC_RAW, SRC_RAW,    SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd49: ins = mk(OP_MUL,  SRC_P11, SRC_R3,     SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd50: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd16, 1'b0, 1'b0);
            6'd51: ins = mk(OP_MUL,  SRC_R3,  SRC_RAW,    SRC_R3, 6'd0,  1'b0, 1'b0);
            6'd52: ins = mk(OP_SDIV, SRC_R3,  SRC_ZERO,   SRC_R3, 6'd7,  1'b0, 1'b0);
            6'd53: ins = mk(OP_ADD,  SRC_R2,  SRC_R3,     SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd54: ins = mk(OP_MUL,  SRC_R2,  SRC_K25,    SRC_R2, 6'd0,  1'b0, 1'b0);
            6'd55: ins = mk(OP_SHR,  SRC_R2,  SRC_ZERO,   SRC_R2, 6'd40, 1'b0, 1'b1);
            default: ins = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_R7, 6'd0, 1'b0, 1'b1);
        endcase
        return ins;
    endfunction

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
// Top level of the barometer temperature and pressure compensation block.

// Each input word is a raw 24-bit conversion tagged temperature (kind 0) or
// pressure (kind 1); the block answers each with exactly one result word in
// 0.01 degC or 0.01 Pa, computed with 64-bit wrapping integer arithmetic from
// the 14 calibration coefficients held in four configuration registers. A
// temperature word also updates the stored linearized temperature that later
// pressure words use (zero after reset). The work runs as a microprogram on
// one shared unit with a 32x32 multiplier: every step first reads the
// scratch registers, then executes an add, subtract or shift, or a 64-bit
// product built from three partial products over successive multiply
// phases. o_ready rises in the same cycle as the result. The block is busy
// for the whole computation, but a finished result may wait in the output
// register while the next word is accepted.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port.
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_kind,
    input  logic [RAW_W-1:0]        i_raw_sample,
    // Output channel.
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_result_kind,
    output logic signed [DATA_W-1:0] o_compensated
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    localparam logic [1:0] MUL_LAST = 2'd3;

    // Sequencer and control state.
    t_state                 r_state;
    logic [PC_W-1:0]        r_pc;
    logic [1:0]             r_phase;
    logic                   r_kind;
    logic [RAW_W-1:0]       r_raw;
    logic [DATA_W-1:0]      r_lin_temp;

    // Configuration registers.
    logic [TEMP_W-1:0]      r_temp_coeffs;
    logic [PRESS_AB_W-1:0]  r_press_a;
    logic [PRESS_AB_W-1:0]  r_press_b;
    logic [PRESS_C_W-1:0]   r_press_c;

    // Scratch registers and registered operands.
    logic [DATA_W-1:0]      r_scr [SCR_DEPTH];
    logic [DATA_W-1:0]      r_mem_a;
    logic [DATA_W-1:0]      r_mem_b;
    logic [DATA_W-1:0]      r_oth_a;
    logic [DATA_W-1:0]      r_oth_b;
    logic                   r_a_mem;
    logic                   r_b_mem;

    // Multiply accumulation.
    logic [DATA_W-1:0]      r_acc;
    logic [DATA_W-1:0]      r_prod;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [DATA_W-1:0]      r_out_val;

    t_instr                 w_ins;
    logic [4:0]             w_sa;
    logic [4:0]             w_sb;
    logic [4:0]             w_sd;
    logic [DATA_W-1:0]      w_a;
    logic [DATA_W-1:0]      w_b;
    logic [31:0]            w_mul_x;
    logic [31:0]            w_mul_y;
    logic [DATA_W-1:0]      w_prod;
    logic [DATA_W-1:0]      w_bias;
    logic [DATA_W-1:0]      w_sdiv;
    logic [DATA_W-1:0]      w_result;
    logic                   w_fin;
    logic                   w_stall;
    logic                   w_commit;

    // Value of a source that is not a scratch register.
    function automatic logic [DATA_W-1:0] src_value(
        input t_src                  s,
        input logic [TEMP_W-1:0]     tc,
        input logic [PRESS_AB_W-1:0] pa,
        input logic [PRESS_AB_W-1:0] pb,
        input logic [PRESS_C_W-1:0]  pc,
        input logic [RAW_W-1:0]      raw,
        input logic [DATA_W-1:0]     lt
    );
        logic [DATA_W-1:0] v;
        case (s)
            SRC_RAW:    v = {{(DATA_W-RAW_W){1'b0}}, raw};
            SRC_LT:     v = lt;
            SRC_T1:     v = {48'd0, tc[15:0]};
            SRC_T2:     v = {48'd0, tc[31:16]};
            SRC_T3:     v = {{56{tc[39]}}, tc[39:32]};
            SRC_P1:     v = {{48{pa[15]}}, pa[15:0]};
            SRC_P2:     v = {{48{pa[31]}}, pa[31:16]};
            SRC_P3:     v = {{56{pa[39]}}, pa[39:32]};
            SRC_P4:     v = {{56{pa[47]}}, pa[47:40]};
            SRC_P5:     v = {48'd0, pb[15:0]};
            SRC_P6:     v = {48'd0, pb[31:16]};
            SRC_P7:     v = {{56{pb[39]}}, pb[39:32]};
            SRC_P8:     v = {{56{pb[47]}}, pb[47:40]};
            SRC_P9:     v = {{48{pc[15]}}, pc[15:0]};
            SRC_P10:    v = {{56{pc[23]}}, pc[23:16]};
            SRC_P11:    v = {{56{pc[31]}}, pc[31:24]};
            SRC_K16384: v = 64'd16384;
            SRC_K25:    v = 64'd25;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Current microinstruction.
    assign w_ins = prog_rom(r_pc);
    assign w_sa  = w_ins.src_a;
    assign w_sb  = w_ins.src_b;
    assign w_sd  = w_ins.dst;

    // Operands come from the scratch read or from the other sources.
    assign w_a = r_a_mem ? r_mem_a : r_oth_a;
    assign w_b = r_b_mem ? r_mem_b : r_oth_b;

    // Shared 32x32 multiplier: low*low, low*high, high*low over the phases.
    assign w_mul_x = (r_phase == 2'd2) ? w_a[63:32] : w_a[31:0];
    assign w_mul_y = (r_phase == 2'd1) ? w_b[63:32] : w_b[31:0];
    assign w_prod  = w_mul_x * w_mul_y;

    // Signed division by a power of two, rounding toward zero.
    assign w_bias = w_a[DATA_W-1] ? ((64'd1 << w_ins.sh) - 64'd1) : '0;
    assign w_sdiv = DATA_W'($signed(w_a + w_bias) >>> w_ins.sh);

    // Result of the current step.
    always_comb begin
        case (w_ins.op)
            OP_ADD:  w_result = w_a + w_b;
            OP_SUB:  w_result = w_a - w_b;
            OP_MUL:  w_result = r_acc + r_prod;
            OP_SHL:  w_result = w_a << w_ins.sh;
            OP_SHR:  w_result = w_a >> w_ins.sh;
            OP_SDIV: w_result = w_sdiv;
            default: w_result = '0;
        endcase
    end

    // A step finishes when its result is ready and, for the last step, the
    // output register is free or being emptied.
    assign w_fin    = (w_ins.op != OP_MUL) || (r_phase == MUL_LAST);
    assign w_stall  = w_ins.last && r_out_valid && !i_ready;
    assign w_commit = (r_state == ST_EXEC) && w_fin && !w_stall;

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pc          <= PC_TEMP;
            r_phase       <= 2'd0;
            r_lin_temp    <= '0;
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_press_c     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TEMP:    r_temp_coeffs <= i_cfg_data[TEMP_W-1:0];
                    CFG_PRESS_A: r_press_a     <= i_cfg_data[PRESS_AB_W-1:0];
                    CFG_PRESS_B: r_press_b     <= i_cfg_data[PRESS_AB_W-1:0];
                    CFG_PRESS_C: r_press_c     <= i_cfg_data[PRESS_C_W-1:0];
                    default: ;
                endcase
            end

            // The output register fills at the end of a program, else empties when taken.
            if (w_commit && w_ins.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_raw   <= i_raw_sample;
                        r_pc    <= i_kind ? PC_PRESS : PC_TEMP;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_phase <= 2'd0;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (w_fin) begin
                        if (!w_stall) begin
                            r_phase <= 2'd0;
                            if (w_ins.wr_lt) begin
                                r_lin_temp <= w_result;
                            end
                            if (w_ins.last) begin
                                r_out_kind  <= r_kind;
                                r_out_val   <= w_result;
                                r_state     <= ST_IDLE;
                            end else begin
                                r_pc    <= r_pc + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                    end else begin
                        // Partial products of a 64-bit wrapping multiply.
                        r_phase <= r_phase + 1'b1;
                        case (r_phase)
                            2'd0: begin
                                r_prod <= w_prod;
                            end
                            2'd1: begin
                                r_acc  <= r_prod;
                                r_prod <= {w_prod[31:0], 32'd0};
                            end
                            2'd2: begin
                                r_acc  <= r_acc + r_prod;
                                r_prod <= {w_prod[31:0], 32'd0};
                            end
                            default: ;
                        endcase
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scratch registers: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_scr[w_sd[SCR_AW-1:0]] <= w_result;
        end
        if (r_state == ST_READ) begin
            r_mem_a <= r_scr[w_sa[SCR_AW-1:0]];
            r_mem_b <= r_scr[w_sb[SCR_AW-1:0]];
            r_a_mem <= (w_sa < 5'(SCR_DEPTH));
            r_b_mem <= (w_sb < 5'(SCR_DEPTH));
            r_oth_a <= src_value(w_ins.src_a, r_temp_coeffs, r_press_a, r_press_b,
                                 r_press_c, r_raw, r_lin_temp);
            r_oth_b <= src_value(w_ins.src_b, r_temp_coeffs, r_press_a, r_press_b,
                                 r_press_c, r_raw, r_lin_temp);
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_compensated = $signed(r_out_val);

`ifndef SYNTHESIS
    // An accepted word always starts the microprogram.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_READ))
        else $error("accepted word did not start the sequencer");

    // Multiply phases only advance inside a multiply step.
    a_phase_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 2'd0) |-> (r_state == ST_EXEC && w_ins.op == OP_MUL))
        else $error("multiply phase active outside a multiply step");

    // A new result word appears only at the end of a program.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_EXEC && w_ins.last))
        else $error("result word raised outside the last step");

    // The stored linearized temperature changes only during a temperature word.
    a_lin_temp_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_lin_temp) |-> $past(r_state == ST_EXEC && w_ins.wr_lt && !r_kind))
        else $error("linearized temperature changed outside a temperature word");
`endif

endmodule

// ===== test/baro_temp_pressure_compensation_checker.sv =====
// Checker that predicts and compares every result word of the barometer compensation block.
module baro_temp_pressure_compensation_checker
    import btpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write port, watched to track the coefficients.
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_kind,
    input  logic [RAW_W-1:0]         i_raw_sample,
    // Output channel.
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_result_kind,
    input  logic signed [DATA_W-1:0] i_compensated,
    // Status for the testbench top.
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    // One predicted result word.
    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] value;
    } t_comp_word;

    t_comp_word expected_words[$];

    // Local copy of the coefficient registers and the linearized temperature.
    logic [TEMP_W-1:0]     temp_coeffs_q;
    logic [PRESS_AB_W-1:0] press_a_q;
    logic [PRESS_AB_W-1:0] press_b_q;
    logic [PRESS_C_W-1:0]  press_c_q;
    logic [DATA_W-1:0]     lin_temp_q;

    // Signed division by 2^k, rounding toward zero.
    function automatic logic [63:0] div_pow2_trunc(input logic [63:0] x, input int unsigned k);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? (64'd0 - x) : x;
        q   = mag >> k;
        return x[63] ? (64'd0 - q) : q;
    endfunction

    function automatic logic [63:0] sext8(input logic [7:0] x);
        return {{56{x[7]}}, x};
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    // Temperature in 0.01 degC; also refreshes the linearized temperature.
    function automatic logic [63:0] compensate_temperature(input logic [RAW_W-1:0] raw);
        logic [63:0] t1, t2, t3, a, b, c, d, e;
        t1 = {48'd0, temp_coeffs_q[15:0]};
        t2 = {48'd0, temp_coeffs_q[31:16]};
        t3 = sext8(temp_coeffs_q[39:32]);
        a  = {40'd0, raw} - (t1 << 8);
        b  = t2 * a;
        c  = a * a;
        d  = c * t3;
        e  = (b << 18) + d;
        lin_temp_q = div_pow2_trunc(e, 32);
        return div_pow2_trunc(lin_temp_q * 64'd25, 14);
    endfunction

    // Pressure in 0.01 Pa from the stored linearized temperature.
    function automatic logic [63:0] compensate_pressure(input logic [RAW_W-1:0] raw_in);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic [63:0] t, raw, sq, cube, offset, sens, lin, quad, cub, total;
        p1  = sext16(press_a_q[15:0]);
        p2  = sext16(press_a_q[31:16]);
        p3  = sext8(press_a_q[39:32]);
        p4  = sext8(press_a_q[47:40]);
        p5  = {48'd0, press_b_q[15:0]};
        p6  = {48'd0, press_b_q[31:16]};
        p7  = sext8(press_b_q[39:32]);
        p8  = sext8(press_b_q[47:40]);
        p9  = sext16(press_c_q[15:0]);
        p10 = sext8(press_c_q[23:16]);
        p11 = sext8(press_c_q[31:24]);
        t   = lin_temp_q;
        raw = {40'd0, raw_in};

        sq     = t * t;
        cube   = div_pow2_trunc(div_pow2_trunc(sq, 6) * t, 8);
        offset = (p5 << 47)
               + div_pow2_trunc(p8 * cube, 5)
               + p7 * sq * 64'd16
               + p6 * t * 64'd4194304;
        sens   = ((p1 - 64'd16384) << 46)
               + div_pow2_trunc(p4 * cube, 5)
               + p3 * sq * 64'd4
               + (p2 - 64'd16384) * t * 64'd2097152;

        lin   = div_pow2_trunc(sens, 24) * raw;
        quad  = p10 * t + 64'd65536 * p9;
        quad  = div_pow2_trunc(quad * raw, 13);
        quad  = div_pow2_trunc(quad * raw, 9);
        cub   = div_pow2_trunc(p11 * (raw * raw), 16);
        cub   = div_pow2_trunc(cub * raw, 7);
        total = div_pow2_trunc(offset, 2) + lin + quad + cub;
        return (total * 64'd25) >> 40;
    endfunction

    // Track configuration, compare accepted results, predict accepted inputs.
    always @(posedge i_clk) begin
        t_comp_word want;
        t_comp_word fresh;
        if (!i_rst_n) begin
            temp_coeffs_q = '0;
            press_a_q     = '0;
            press_b_q     = '0;
            press_c_q     = '0;
            lin_temp_q    = '0;
            o_fail_count  = 0;
            o_checked     = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TEMP:    temp_coeffs_q = i_cfg_data[TEMP_W-1:0];
                    CFG_PRESS_A: press_a_q     = i_cfg_data[PRESS_AB_W-1:0];
                    CFG_PRESS_B: press_b_q     = i_cfg_data[PRESS_AB_W-1:0];
                    CFG_PRESS_C: press_c_q     = i_cfg_data[PRESS_C_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, kind %0d value %0d",
                             $time, i_result_kind, i_compensated);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    o_checked++;
                    if (i_result_kind !== want.kind) begin
                        $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, i_result_kind);
                        o_fail_count++;
                    end
                    if (i_compensated !== want.value) begin
                        $display("%0t: compensated mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.value), i_compensated);
                        o_fail_count++;
                    end
                end
            end

            // A high kind bit marks a pressure word.
            if (i_in_valid && i_in_ready) begin
                fresh.kind  = i_kind;
                fresh.value = i_kind ? compensate_pressure(i_raw_sample)
                                     : compensate_temperature(i_raw_sample);
                expected_words.push_back(fresh);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== test/baro_temp_pressure_compensation_tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the barometer compensation block.
module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // Coefficient settings that can be loaded.
    localparam int SET_RANDOM    = 0;
    localparam int SET_ONES      = 1;
    localparam int SET_MAX_POS   = 2;
    localparam int SET_MIN_NEG   = 3;
    localparam int SET_TYPICAL   = 4;

    localparam int  HOLD_CYCLES     = 1500;
    localparam int  WORDS_PER_PHASE = 315;
    localparam int  SETTLE_CYCLES   = 200;
    localparam longint TIMEOUT      = 64'd48_000_000;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [CFG_DATA_W-1:0]    cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     in_kind    = 1'b0;
    logic [RAW_W-1:0]         in_raw     = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     out_kind;
    logic signed [DATA_W-1:0] out_value;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int temp_words    = 0;
    int press_words   = 0;
    int settings_used = 1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    baro_temp_pressure_compensation u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_kind        (in_kind),
        .i_raw_sample  (in_raw),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_result_kind (out_kind),
        .o_compensated (out_value)
    );

    baro_temp_pressure_compensation_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (in_kind),
        .i_raw_sample  (in_raw),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_result_kind (out_kind),
        .i_compensated (out_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Offer one word, idling first at the current rate, and wait for it to be taken.
    task automatic send_word(input logic kind, input logic [RAW_W-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_kind  = kind;
        in_raw   = raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (kind == KIND_PRESS) press_words++;
        else temp_words++;
    endtask

    // Stop offering, then wait until every predicted result has been taken.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four coefficient registers; most settings put random bits above the temperature and pressure-C widths.
    task automatic load_setting(input int which);
        logic [CFG_DATA_W-1:0] words[4];
        case (which)
            SET_ONES: begin
                words[0] = '1;
                words[1] = '1;
                words[2] = '1;
                words[3] = '1;
            end
            SET_MAX_POS: begin
                words[0] = {8'($urandom), 40'h7F_FFFF_FFFF};
                words[1] = 48'h7F7F_7FFF_7FFF;
                words[2] = 48'h7F7F_FFFF_FFFF;
                words[3] = {16'($urandom), 32'h7F7F_7FFF};
            end
            SET_MIN_NEG: begin
                words[0] = {8'($urandom), 40'h80_0000_0000};
                words[1] = 48'h8080_8000_8000;
                words[2] = 48'h8080_0000_0000;
                words[3] = {16'($urandom), 32'h8080_8000};
            end
            SET_TYPICAL: begin
                words[0] = {8'($urandom), 40'hF9_6743_6B70};
                words[1] = 48'h010C_F0A3_DF20;
                words[2] = 48'hFB0B_7A12_5A3C;
                words[3] = {16'($urandom), 32'h12E3_1A2B};
            end
            default: begin
                for (int i = 0; i < 4; i++) words[i] = {16'($urandom), 32'($urandom)};
            end
        endcase
        cfg_index = CFG_TEMP;
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_wr_en = 1'b1;
            case (i)
                0: cfg_index = CFG_TEMP;
                1: cfg_index = CFG_PRESS_A;
                2: cfg_index = CFG_PRESS_B;
                default: cfg_index = CFG_PRESS_C;
            endcase
            cfg_data = words[i];
        end
        @(negedge clk);
        cfg_wr_en = 1'b0;
        settings_used++;
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 24'h800000;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Mostly a temperature word followed by a few pressure words; the rest lone words.
    task automatic run_random_words(input int count);
        int sent;
        int n_press;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 70) begin
                send_word(KIND_TEMP, pick_raw());
                n_press = $urandom_range(4, 1);
                repeat (n_press) send_word(KIND_PRESS, pick_raw());
                sent += 1 + n_press;
            end else begin
                send_word(1'($urandom), pick_raw());
                sent++;
            end
        end
    endtask

    // Output side: random ready, or a long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("Timeout with %0d results still expected.", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Main stimulus.
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 59;

        // Pressure before any temperature, with reset coefficients.
        send_word(KIND_PRESS, 24'h000000);
        send_word(KIND_PRESS, 24'hFFFFFF);
        send_word(KIND_TEMP, 24'h7FFFFF);
        drain_results();

        // Typical coefficients; the first pressure still sees a zero temperature.
        load_setting(SET_TYPICAL);
        send_word(KIND_PRESS, 24'h6C0000);
        send_word(KIND_TEMP, 24'h000000);
        send_word(KIND_TEMP, 24'hFFFFFF);
        send_word(KIND_TEMP, 24'h800000);
        send_word(KIND_TEMP, 24'h7E8A00);
        send_word(KIND_PRESS, 24'h000000);
        send_word(KIND_PRESS, 24'hFFFFFF);
        send_word(KIND_PRESS, 24'h555555);
        send_word(KIND_PRESS, 24'hAAAAAA);
        send_word(KIND_PRESS, 24'h65A000);
        drain_results();

        // Extreme coefficients drive overflow and negative divisions.
        load_setting(SET_MAX_POS);
        send_word(KIND_TEMP, 24'hFFFFFF);
        send_word(KIND_PRESS, 24'hFFFFFF);
        send_word(KIND_TEMP, 24'h000000);
        send_word(KIND_PRESS, 24'h000000);
        drain_results();
        load_setting(SET_MIN_NEG);
        send_word(KIND_TEMP, 24'h000000);
        send_word(KIND_PRESS, 24'hFFFFFF);
        send_word(KIND_TEMP, 24'hFFFFFF);
        send_word(KIND_PRESS, 24'h000000);
        drain_results();
        load_setting(SET_ONES);
        send_word(KIND_TEMP, 24'h123456);
        send_word(KIND_PRESS, 24'hFFFFFF);
        drain_results();

        // Long output hold-off so the block fills and stalls its input.
        load_setting(SET_TYPICAL);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (6) send_word(KIND_TEMP, pick_raw());
        repeat (2) send_word(KIND_PRESS, pick_raw());
        drain_results();

        // Random phases under changing idle patterns and coefficient settings.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0, 1: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 59;
                end
                2, 3: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                1: load_setting(SET_ONES);
                3: load_setting(SET_MAX_POS);
                4: load_setting(SET_MIN_NEG);
                5: load_setting(SET_TYPICAL);
                default: load_setting(SET_RANDOM);
            endcase
            run_random_words(WORDS_PER_PHASE);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d temperature and %0d pressure words",
                 checked, temp_words, press_words);
        $display("across %0d coefficient settings, with idling on both sides and a hold-off.",
                 settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== baro_temp_pressure_compensation.f =====
sv/btpc_pkg.sv
sv/baro_temp_pressure_compensation.sv
test/baro_temp_pressure_compensation_checker.sv
test/baro_temp_pressure_compensation_tb.sv
